>>> sv/crfvd_pkg.sv
// Package for the CRF Viterbi label decoder: sizes, codes and sequencer states.
// No dependencies; imported by crf_viterbi_label_decoder.
`timescale 1ns / 1ps
package crfvd_pkg;
  localparam int MAX_LABELS = 16;
  localparam int MAX_LENGTH = 64;
  localparam int SCORE_BITS = 24;
  localparam int LBL_W      = $clog2(MAX_LABELS);
  localparam int CNT_W      = $clog2(MAX_LABELS + 1);
  localparam int PIDX_W     = $clog2(MAX_LENGTH);
  localparam int POS_W      = $clog2(MAX_LENGTH + 1);
  localparam int PATH_W     = 32;
  localparam int SUM_W      = PATH_W + 2;
  localparam int IN_DATA_W  = 2 * LBL_W + SCORE_BITS;
  localparam int OUT_DATA_W = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WRITE, S_DEC, S_BEST, S_TRACE, S_TWAIT, S_ORD, S_OLD
  } state_t;
endpackage

>>> sv/crfvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module crfvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/crf_viterbi_label_decoder.sv
// Linear-chain CRF Viterbi decoder: transition table, path score banks,
// back pointers and decoded labels in crfvd_ram instances; uses crfvd_pkg.
//
// channel | dir | handshake           | word
// s_      | in  | s_tvalid/s_tready   | tuser=operation, tlast=end_of_sentence, tdata
// m_      | out | m_tvalid/m_tready   | tuser=too_long, tlast=last_label, tdata
// cfg_    | in  | cfg_valid/cfg_ready | label_count
//
// A transition load is written straight from idle. An emission at position 0
// or past the maximum length is also handled in idle; any other runs the
// one-read-per-cycle scan of the previous path score bank, then a write.
// End of sentence adds a best search, a traceback of each position, then the
// output words, each sent once the previous one is taken; the last word can wait
// while input resumes.
// Reset is synchronous; memories are not cleared. Input stalls while busy.
module crf_viterbi_label_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] from_label, [7:4] to_label, [31:8] score
  input  logic [crfvd_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic        s_tlast,
  // [0] operation
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] predicted_label, [7:4] zero
  output logic [crfvd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic        m_tlast,
  // [0] too_long
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [crfvd_pkg::CNT_W-1:0] cfg_data
);
  import crfvd_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  label_count, nl, cursor, iss;
  logic              bank, ovf;
  logic [POS_W-1:0]  pos, k;
  logic signed [SCORE_BITS-1:0] it_score;
  logic [LBL_W-1:0]  it_t, rd_idx, sum_idx, bestp, lab;
  logic              it_eos, rd_v, sum_v;
  logic signed [PATH_W-1:0] sum, best;
  logic [PIDX_W-1:0] tp;

  logic        acc;
  logic        issue, scan_done, k_last;
  logic [LBL_W-1:0] from_in, to_in;
  logic signed [SCORE_BITS-1:0] score_in;

  logic                         tr_we;
  logic [2*LBL_W-1:0]           tr_waddr, tr_raddr;
  logic signed [SCORE_BITS-1:0] tr_rdata;
  logic                         ps_we;
  logic [LBL_W:0]               ps_waddr, ps_raddr;
  logic signed [PATH_W-1:0]     ps_wdata, ps_rdata;
  logic                         bp_we;
  logic [PIDX_W+LBL_W-1:0]      bp_waddr, bp_raddr;
  logic [LBL_W-1:0]             bp_rdata;
  logic                         dc_we;
  logic [LBL_W-1:0]             dc_rdata;

  function automatic logic signed [PATH_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(PATH_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) return {1'b0, {(PATH_W-1){1'b1}}};
    else if (v < lo) return {1'b1, {(PATH_W-1){1'b0}}};
    else return v[PATH_W-1:0];
  endfunction

  assign from_in  = s_tdata[LBL_W-1:0];
  assign to_in    = s_tdata[2*LBL_W-1:LBL_W];
  assign score_in = s_tdata[IN_DATA_W-1:2*LBL_W];

  assign nl = (label_count == '0) ? CNT_W'(1) :
              (label_count > CNT_W'(MAX_LABELS)) ? CNT_W'(MAX_LABELS) : label_count;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = s_tvalid && s_tready;
  assign issue     = ((state == S_SCAN) || (state == S_BEST)) && (iss < nl);
  assign scan_done = (iss >= nl) && !rd_v && !sum_v;
  assign k_last    = (k == pos - POS_W'(1));

  assign tr_raddr = {iss[LBL_W-1:0], it_t};
  assign ps_raddr = {~bank, iss[LBL_W-1:0]};
  assign bp_raddr = {tp, lab};

  crfvd_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_LABELS * MAX_LABELS)) u_trans (
    .clk, .we(tr_we), .waddr(tr_waddr), .wdata(score_in), .raddr(tr_raddr),
    .rdata(tr_rdata));
  crfvd_ram #(.WIDTH(PATH_W), .DEPTH(2 * MAX_LABELS)) u_path (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata), .raddr(ps_raddr),
    .rdata(ps_rdata));
  crfvd_ram #(.WIDTH(LBL_W), .DEPTH(MAX_LENGTH * MAX_LABELS)) u_bp (
    .clk, .we(bp_we), .waddr(bp_waddr), .wdata(bestp), .raddr(bp_raddr),
    .rdata(bp_rdata));
  crfvd_ram #(.WIDTH(LBL_W), .DEPTH(MAX_LENGTH)) u_dec (
    .clk, .we(dc_we), .waddr(tp), .wdata(lab), .raddr(k[PIDX_W-1:0]),
    .rdata(dc_rdata));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && s_tuser == OP_EMIT) begin
          if (pos >= POS_W'(MAX_LENGTH) || pos == '0) begin
            state_next = s_tlast ? S_DEC : S_IDLE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN:  if (scan_done) state_next = S_WRITE;
      S_WRITE: state_next = it_eos ? S_DEC : S_IDLE;
      S_DEC:   state_next = (pos == '0) ? S_IDLE : S_BEST;
      S_BEST:  if (scan_done) state_next = S_TRACE;
      S_TRACE: state_next = (tp == '0) ? S_ORD : S_TWAIT;
      S_TWAIT: state_next = S_TRACE;
      S_ORD:   if (!m_tvalid || m_tready) state_next = S_OLD;
      S_OLD:   state_next = k_last ? S_IDLE : S_ORD;
      default: state_next = S_IDLE;
    endcase
  end

  // memory write controls
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = {from_in, to_in};
    ps_we    = 1'b0;
    ps_waddr = {bank, it_t};
    ps_wdata = best;
    bp_we    = 1'b0;
    bp_waddr = {pos[PIDX_W-1:0], it_t};
    dc_we    = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc && s_tuser == OP_LOAD) begin
          tr_we = 1'b1;
        end else if (acc && pos == '0) begin
          ps_we    = 1'b1;
          ps_waddr = {bank, cursor[LBL_W-1:0]};
          ps_wdata = PATH_W'(score_in);
        end
      end
      S_WRITE: begin
        ps_we = 1'b1;
        bp_we = 1'b1;
      end
      S_TRACE: dc_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      label_count <= CNT_W'(16);
      bank        <= 1'b0;
      pos         <= '0;
      cursor      <= '0;
      ovf         <= 1'b0;
      rd_v        <= 1'b0;
      sum_v       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) label_count <= cfg_data;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      // score pipeline: read, add and saturate (plain pass-through in best search), compare
      rd_v   <= issue;
      rd_idx <= iss[LBL_W-1:0];
      if (issue) iss <= iss + CNT_W'(1);
      sum_v   <= rd_v;
      sum_idx <= rd_idx;
      if (state == S_BEST) begin
        sum <= ps_rdata;
      end else begin
        sum <= sat32(SUM_W'(ps_rdata) + SUM_W'(it_score) + SUM_W'(tr_rdata));
      end
      if (sum_v && (sum_idx == '0 || sum > best)) begin
        best  <= sum;
        bestp <= sum_idx;
      end

      case (state)
        S_IDLE: begin
          if (acc && s_tuser == OP_EMIT) begin
            it_score <= score_in;
            it_t     <= cursor[LBL_W-1:0];
            it_eos   <= s_tlast;
            iss      <= '0;
            if (pos >= POS_W'(MAX_LENGTH)) begin
              ovf <= 1'b1;
            end else if (pos == '0) begin
              if (CNT_W'(cursor[LBL_W-1:0]) + CNT_W'(1) >= nl) begin
                bank   <= ~bank;
                pos    <= pos + POS_W'(1);
                cursor <= '0;
              end else begin
                cursor <= CNT_W'(cursor[LBL_W-1:0]) + CNT_W'(1);
              end
            end
          end
        end
        S_WRITE: begin
          if (CNT_W'(it_t) + CNT_W'(1) >= nl) begin
            bank   <= ~bank;
            pos    <= pos + POS_W'(1);
            cursor <= '0;
          end else begin
            cursor <= CNT_W'(it_t) + CNT_W'(1);
          end
        end
        S_DEC: begin
          iss <= '0;
          if (pos == '0) begin
            cursor <= '0;
            ovf    <= 1'b0;
          end
        end
        S_BEST: begin
          if (scan_done) begin
            lab <= bestp;
            tp  <= pos[PIDX_W-1:0] - PIDX_W'(1);
          end
        end
        S_TRACE: k <= '0;
        S_TWAIT: begin
          lab <= bp_rdata;
          tp  <= tp - PIDX_W'(1);
        end
        S_OLD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= OUT_DATA_W'(dc_rdata);
          m_tlast  <= k_last;
          m_tuser  <= ovf;
          k        <= k + POS_W'(1);
          if (k_last) begin
            pos    <= '0;
            cursor <= '0;
            ovf    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_LENGTH)) else $error("position count beyond maximum length");
  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos != '0 && pos < POS_W'(MAX_LENGTH)))
    else $error("scan started without a previous position");
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_OLD) |-> !m_tvalid) else $error("output word overwritten");
  a_trace_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRACE) |-> (pos != '0)) else $error("traceback with no positions");
endmodule
